// ===== rtl/core/line_sensor_centroid_pid_steering_assert.svh =====
// Assertion macros shared by the line sensor steering RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef LINE_SENSOR_CENTROID_PID_STEERING_ASSERT_SVH
`define LINE_SENSOR_CENTROID_PID_STEERING_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define LSCP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lscp assertion failed");
// Implication checked on every clock edge outside reset.
`define LSCP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lscp implication failed");
`else
`define LSCP_ASSERT(lbl, clk, rstn, prop)
`define LSCP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/lscp_pkg.sv =====
// Package for the line sensor centroid / PID steering block.
// Types, widths, codes and helper functions; no dependencies.
package lscp_pkg;

  localparam int SLOT_W     = 4;
  localparam int SAMPLE_W   = 12;
  localparam int LINE_W     = 16;
  localparam int WSUM_W     = 15;
  localparam int HIT_W      = 5;
  localparam int POS_W      = 11;
  localparam int ERR_W      = 12;
  localparam int DER_W      = 13;
  localparam int ED_W       = 14;
  localparam int ACC_W      = 24;
  localparam int GAIN_W     = 8;
  localparam int DUTY_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIVCNT_W   = 4;

  localparam logic [POS_W-1:0] POS_MAX     = 11'd1500;
  localparam int               WEIGHT_STEP = 100;

  typedef enum logic [1:0] {
    FUNC_BLACK = 2'd0,
    FUNC_WHITE = 2'd1,
    FUNC_RUN   = 2'd2
  } func_e;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_A     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_B     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WHITE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT   = 3'd7;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_d;
    logic [GAIN_W-1:0] gain_i;
    logic [DUTY_W-1:0] base_duty_a;
    logic [DUTY_W-1:0] base_duty_b;
    logic [DUTY_W-1:0] max_duty;
    logic              line_white;
    logic [POS_W-1:0]  setpoint;
  } cfg_t;

  typedef struct packed {
    logic load_item;
    logic eval;
    logic div_init;
    logic div_step;
    logic err_calc;
    logic mac_p;
    logic mac_d;
    logic mac_i;
    logic duty_calc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic run_last;
    logic out_free;
  } status_t;

  // Slot weight: 1500 at slot 0, down by 100 per slot.
  function automatic logic [POS_W-1:0] slot_weight(input logic [SLOT_W-1:0] slot);
    int w;
    w = int'(POS_MAX) - WEIGHT_STEP * int'(slot);
    return POS_W'(w);
  endfunction

endpackage

// ===== rtl/core/lscp_in_if.sv =====
// Input channel of the steering block: valid/ready plus one sensor sample.
// Depends on lscp_pkg.
interface lscp_in_if
  import lscp_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [1:0]          func;
  logic [SLOT_W-1:0]   sensor_slot;
  logic [SAMPLE_W-1:0] sample;
  logic                last;

  modport source (output valid, func, sensor_slot, sample, last, input ready);
  modport sink   (input valid, func, sensor_slot, sample, last, output ready);
endinterface

// ===== rtl/core/lscp_out_if.sv =====
// Result channel of the steering block: valid/ready plus duties and position.
// Depends on lscp_pkg.
interface lscp_out_if
  import lscp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [DUTY_W-1:0]        duty_a;
  logic [DUTY_W-1:0]        duty_b;
  logic [POS_W-1:0]         position;
  logic signed [ERR_W-1:0]  pos_error;
  logic [LINE_W-1:0]        line_bits;
  logic                     no_line;

  modport source (output valid, duty_a, duty_b, position, pos_error, line_bits, no_line,
                  input ready);
  modport sink   (input valid, duty_a, duty_b, position, pos_error, line_bits, no_line,
                  output ready);
endinterface

// ===== rtl/core/lscp_cfg.sv =====
// Configuration register bank of the steering block.
// Depends on lscp_pkg.
module lscp_cfg
  import lscp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAIN_P:     cfg_d.gain_p      = cfg_wdata_i[GAIN_W-1:0];
        CFG_GAIN_D:     cfg_d.gain_d      = cfg_wdata_i[GAIN_W-1:0];
        CFG_GAIN_I:     cfg_d.gain_i      = cfg_wdata_i[GAIN_W-1:0];
        CFG_BASE_A:     cfg_d.base_duty_a = cfg_wdata_i[DUTY_W-1:0];
        CFG_BASE_B:     cfg_d.base_duty_b = cfg_wdata_i[DUTY_W-1:0];
        CFG_MAX_DUTY:   cfg_d.max_duty    = cfg_wdata_i[DUTY_W-1:0];
        CFG_LINE_WHITE: cfg_d.line_white  = cfg_wdata_i[0];
        CFG_SETPOINT:   cfg_d.setpoint    = cfg_wdata_i[POS_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p      <= 8'd2;
      cfg_q.gain_d      <= 8'd0;
      cfg_q.gain_i      <= 8'd0;
      cfg_q.base_duty_a <= 16'd500;
      cfg_q.base_duty_b <= 16'd800;
      cfg_q.max_duty    <= 16'd2506;
      cfg_q.line_white  <= 1'b0;
      cfg_q.setpoint    <= 11'd750;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/lscp_ctrl.sv =====
// Sequencer of the steering block: accepts items, steps the divider and MAC.
// Depends on lscp_pkg and the assertion macro header.
`include "line_sensor_centroid_pid_steering_assert.svh"
module lscp_ctrl
  import lscp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EVAL     = 4'd1;
  localparam logic [3:0] S_DIV_INIT = 4'd2;
  localparam logic [3:0] S_DIV      = 4'd3;
  localparam logic [3:0] S_ERR      = 4'd4;
  localparam logic [3:0] S_MAC_P    = 4'd5;
  localparam logic [3:0] S_MAC_D    = 4'd6;
  localparam logic [3:0] S_MAC_I    = 4'd7;
  localparam logic [3:0] S_DUTY     = 4'd8;
  localparam logic [3:0] S_OUT      = 4'd9;

  localparam logic [DIVCNT_W-1:0] DIV_LAST = DIVCNT_W'(WSUM_W - 1);

  logic [3:0]          state_q, state_d;
  logic [DIVCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = status_i.run_last ? S_DIV_INIT : S_IDLE;
      end
      S_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = S_ERR;
        end
      end
      S_ERR: begin
        cmd_o.err_calc = 1'b1;
        state_d        = S_MAC_P;
      end
      S_MAC_P: begin
        cmd_o.mac_p = 1'b1;
        state_d     = S_MAC_D;
      end
      S_MAC_D: begin
        cmd_o.mac_d = 1'b1;
        state_d     = S_MAC_I;
      end
      S_MAC_I: begin
        cmd_o.mac_i = 1'b1;
        state_d     = S_DUTY;
      end
      S_DUTY: begin
        cmd_o.duty_calc = 1'b1;
        state_d         = S_OUT;
      end
      S_OUT: begin
        // hold until the result register is free
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `LSCP_ASSERT_IMP(a_div_cnt_range, clk_i, rst_ni, state_q == S_DIV, cnt_q <= DIV_LAST)
  `LSCP_ASSERT_IMP(a_eval_after_idle, clk_i, rst_ni, state_q == S_EVAL, $past(state_q) == S_IDLE)
  `LSCP_ASSERT_IMP(a_err_after_div, clk_i, rst_ni, state_q == S_ERR, $past(cnt_q) == DIV_LAST)

endmodule

// ===== rtl/core/lscp_datapath.sv =====
// Datapath of the steering block: calibration, scan accumulation,
// shift-subtract divider, shared gain multiplier, duty clamp, result register.
// Depends on lscp_pkg and the assertion macro header.
`include "line_sensor_centroid_pid_steering_assert.svh"
module lscp_datapath
  import lscp_pkg::*;
#(
  parameter int NUM_SENSORS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  input  logic [1:0]              func_i,
  input  logic [SLOT_W-1:0]       sensor_slot_i,
  input  logic [SAMPLE_W-1:0]     sample_i,
  input  logic                    last_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output logic [DUTY_W-1:0]       duty_a_o,
  output logic [DUTY_W-1:0]       duty_b_o,
  output logic [POS_W-1:0]        position_o,
  output logic signed [ERR_W-1:0] pos_error_o,
  output logic [LINE_W-1:0]       line_bits_o,
  output logic                    no_line_o
);

  localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  // latched item
  logic [1:0]          func_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [SAMPLE_W-1:0] smp_q;
  logic                last_q;

  // calibration levels
  logic [SAMPLE_W-1:0] black_q [NUM_SENSORS];
  logic [SAMPLE_W-1:0] white_q [NUM_SENSORS];

  // scan state
  logic [LINE_W-1:0]   scan_q;
  logic [WSUM_W-1:0]   wsum_q;
  logic [HIT_W-1:0]    hit_q;
  logic signed [ERR_W-1:0] prev_q;

  // divider
  logic [WSUM_W-1:0]   quo_q;
  logic [HIT_W:0]      rem_q;

  // PID
  logic [POS_W-1:0]        pos_q;
  logic signed [ERR_W-1:0] err_q;
  logic signed [DER_W-1:0] der_q;
  logic signed [ED_W-1:0]  ed_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [DUTY_W-1:0]       duty_a_q, duty_b_q;

  // result register
  logic                    res_valid_q;
  logic [DUTY_W-1:0]       res_duty_a_q, res_duty_b_q;
  logic [POS_W-1:0]        res_pos_q;
  logic signed [ERR_W-1:0] res_err_q;
  logic [LINE_W-1:0]       res_bits_q;
  logic                    res_noline_q;

  logic [IDX_W-1:0]    idx;
  logic                slot_ok;
  logic [SAMPLE_W:0]   lvl_sum;
  logic [SAMPLE_W-1:0] mid;
  logic                hit_bit;
  logic                new_hit;

  assign idx     = IDX_W'(slot_q);
  assign slot_ok = int'(slot_q) < NUM_SENSORS;
  assign lvl_sum = {1'b0, black_q[idx]} + {1'b0, white_q[idx]};
  assign mid     = lvl_sum[SAMPLE_W:1];
  assign hit_bit = (smp_q > mid) ^ cfg_i.line_white;
  assign new_hit = slot_ok && hit_bit && !scan_q[slot_q];

  // divider step
  logic [HIT_W:0] rem_sh, rem_sub;
  logic           rem_ge;
  assign rem_sh  = {rem_q[HIT_W-1:0], quo_q[WSUM_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, hit_q};
  assign rem_sub = rem_sh - {1'b0, hit_q};

  // position and error
  logic [POS_W-1:0]        pos_d;
  logic signed [ERR_W-1:0] err_d;
  always_comb begin
    if (hit_q == '0) begin
      pos_d = '0;
    end else if (quo_q > WSUM_W'(POS_MAX)) begin
      pos_d = POS_MAX;
    end else begin
      pos_d = quo_q[POS_W-1:0];
    end
  end
  assign err_d = $signed({1'b0, pos_d}) - $signed({1'b0, cfg_i.setpoint});

  // shared gain multiplier
  logic signed [GAIN_W:0]  mul_a;
  logic signed [ED_W-1:0]  mul_b;
  logic signed [ACC_W-1:0] prod;
  always_comb begin
    priority if (cmd_i.mac_p) begin
      mul_a = $signed({1'b0, cfg_i.gain_p});
      mul_b = ED_W'(err_q);
    end else if (cmd_i.mac_d) begin
      mul_a = $signed({1'b0, cfg_i.gain_d});
      mul_b = ED_W'(der_q);
    end else begin
      mul_a = $signed({1'b0, cfg_i.gain_i});
      mul_b = ed_q;
    end
  end
  assign prod = mul_a * mul_b;

  // duty sums and clamps
  logic signed [ACC_W:0] acc_ext, base_a_ext, base_b_ext, max_ext, sum_a, sum_b;
  logic [DUTY_W-1:0]     clamp_a, clamp_b;
  assign acc_ext    = {acc_q[ACC_W-1], acc_q};
  assign base_a_ext = {{(ACC_W+1-DUTY_W){1'b0}}, cfg_i.base_duty_a};
  assign base_b_ext = {{(ACC_W+1-DUTY_W){1'b0}}, cfg_i.base_duty_b};
  assign max_ext    = {{(ACC_W+1-DUTY_W){1'b0}}, cfg_i.max_duty};
  assign sum_a      = base_a_ext + acc_ext;
  assign sum_b      = base_b_ext - acc_ext;

  always_comb begin
    if (sum_a < 0) begin
      clamp_a = '0;
    end else if (sum_a > max_ext) begin
      clamp_a = cfg_i.max_duty;
    end else begin
      clamp_a = sum_a[DUTY_W-1:0];
    end
    if (sum_b < 0) begin
      clamp_b = '0;
    end else if (sum_b > max_ext) begin
      clamp_b = cfg_i.max_duty;
    end else begin
      clamp_b = sum_b[DUTY_W-1:0];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q <= func_i;
      slot_q <= sensor_slot_i;
      smp_q  <= sample_i;
      last_q <= last_i;
    end
    if (cmd_i.div_init) begin
      quo_q <= wsum_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[WSUM_W-2:0], rem_ge};
      rem_q <= rem_ge ? rem_sub : rem_sh;
    end
    if (cmd_i.err_calc) begin
      pos_q <= pos_d;
      err_q <= err_d;
    end
    if (cmd_i.mac_p) begin
      acc_q <= prod;
      der_q <= {err_q[ERR_W-1], err_q} - {prev_q[ERR_W-1], prev_q};
    end
    if (cmd_i.mac_d) begin
      acc_q <= acc_q + prod;
      ed_q  <= {{(ED_W-ERR_W){err_q[ERR_W-1]}}, err_q} + {der_q[DER_W-1], der_q};
    end
    if (cmd_i.mac_i) begin
      acc_q <= acc_q + prod;
    end
    if (cmd_i.duty_calc) begin
      duty_a_q <= clamp_a;
      duty_b_q <= clamp_b;
    end
    if (cmd_i.out_load) begin
      res_duty_a_q <= duty_a_q;
      res_duty_b_q <= duty_b_q;
      res_pos_q    <= pos_q;
      res_err_q    <= err_q;
      res_bits_q   <= scan_q;
      res_noline_q <= (hit_q == '0);
    end
  end

  // state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        black_q[i] <= '0;
        white_q[i] <= '0;
      end
      scan_q      <= '0;
      wsum_q      <= '0;
      hit_q       <= '0;
      prev_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.eval && slot_ok) begin
        if (func_q == FUNC_BLACK) begin
          black_q[idx] <= smp_q;
        end
        if (func_q == FUNC_WHITE) begin
          white_q[idx] <= smp_q;
        end
      end
      if (cmd_i.eval && (func_q == FUNC_RUN) && new_hit) begin
        scan_q[slot_q] <= 1'b1;
        wsum_q         <= wsum_q + WSUM_W'(slot_weight(slot_q));
        hit_q          <= hit_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        scan_q <= '0;
        wsum_q <= '0;
        hit_q  <= '0;
        prev_q <= err_q;
      end
      if (cmd_i.out_load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.run_last = (func_q == FUNC_RUN) && last_q;
  assign status_o.out_free = !res_valid_q || res_ready_i;

  assign res_valid_o = res_valid_q;
  assign duty_a_o    = res_duty_a_q;
  assign duty_b_o    = res_duty_b_q;
  assign position_o  = res_pos_q;
  assign pos_error_o = res_err_q;
  assign line_bits_o = res_bits_q;
  assign no_line_o   = res_noline_q;

  `LSCP_ASSERT(a_hit_matches_bits, clk_i, rst_ni, int'(hit_q) == $countones(scan_q))
  `LSCP_ASSERT_IMP(a_valid_from_load, clk_i, rst_ni, $rose(res_valid_q), $past(cmd_i.out_load))
  `LSCP_ASSERT_IMP(a_pos_in_range, clk_i, rst_ni, res_valid_q, res_pos_q <= POS_MAX)

endmodule

// ===== rtl/core/line_sensor_centroid_pid_steering.sv =====
// Line sensor centroid and PID steering block, top level.
// A calibration or mid-scan sample is evaluated and the block returns to idle; a
// scan-closing sample then runs the serial divider, the error step, the P, D and I MAC
// steps and the duty clamp, and its result load waits while an earlier result still
// waits. Samples are taken only in idle, one at a time. Reset: async active low; calibration
// levels, scan state and previous error clear, registers take their defaults.
module line_sensor_centroid_pid_steering
  import lscp_pkg::*;
#(
  parameter int NUM_SENSORS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lscp_in_if.sink               item_i,
  lscp_out_if.source            result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  lscp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  lscp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(item_i.valid),
    .in_ready_o(in_ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  lscp_datapath #(
    .NUM_SENSORS(NUM_SENSORS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .status_o     (status),
    .func_i       (item_i.func),
    .sensor_slot_i(item_i.sensor_slot),
    .sample_i     (item_i.sample),
    .last_i       (item_i.last),
    .res_valid_o  (result_o.valid),
    .res_ready_i  (result_o.ready),
    .duty_a_o     (result_o.duty_a),
    .duty_b_o     (result_o.duty_b),
    .position_o   (result_o.position),
    .pos_error_o  (result_o.pos_error),
    .line_bits_o  (result_o.line_bits),
    .no_line_o    (result_o.no_line)
  );

  assign item_i.ready = in_ready;

endmodule

// ===== bench/tb_line_sensor_centroid_pid_steering.sv =====
// Self-checking bench for the line sensor centroid / PID steering block.
// Drives sensor samples and register writes, predicts each steering result.
// Depends on lscp_pkg, lscp_in_if, lscp_out_if and the block's top level.
`timescale 1ns / 100ps

module tb_line_sensor_centroid_pid_steering;
  import lscp_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         SETTLE_CYC  = 40;
  localparam int         PHASE_ITEMS = 135;

  typedef struct packed {
    logic [1:0]          func;
    logic [SLOT_W-1:0]   slot;
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } sensor_item_t;

  typedef struct {
    logic [DUTY_W-1:0]       duty_a;
    logic [DUTY_W-1:0]       duty_b;
    logic [POS_W-1:0]        position;
    logic signed [ERR_W-1:0] pos_error;
    logic [LINE_W-1:0]       line_bits;
    logic                    no_line;
  } steer_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  lscp_in_if  in_ch ();
  lscp_out_if out_ch ();

  line_sensor_centroid_pid_steering uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (in_ch),
    .result_o   (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the block's registers and scan state.
  cfg_t                    cfg_m;
  logic [SAMPLE_W-1:0]     black_lv [16];
  logic [SAMPLE_W-1:0]     white_lv [16];
  logic [LINE_W-1:0]       scan_bits_m;
  logic [WSUM_W-1:0]       wsum_m;
  logic [HIT_W-1:0]        hits_m;
  logic signed [ERR_W-1:0] prev_err_m;

  sensor_item_t  pending_q [$];
  steer_result_t steer_q [$];
  int  n_queued = 0;
  int  n_taken = 0;
  int  fails = 0;
  int  send_idle_pct = 38;
  int  recv_idle_pct = 63;
  bit  recv_hold = 1'b0;
  bit  hold_go = 1'b0;
  bit  in_took = 1'b0;

  function automatic logic [DUTY_W-1:0] clamp_duty(longint v, logic [DUTY_W-1:0] top);
    if (v < 0) return '0;
    if (v > longint'(top)) return top;
    return DUTY_W'(v);
  endfunction

  // Advance the shadow state by one accepted sample; queue a result on scan close.
  function automatic void track_sample(sensor_item_t it);
    logic [SAMPLE_W:0] mid;
    logic          hit;
    int            pos;
    longint        e, d, term;
    steer_result_t r;
    case (it.func)
      FUNC_BLACK: black_lv[it.slot] = it.sample;
      FUNC_WHITE: white_lv[it.slot] = it.sample;
      FUNC_RUN: begin
        mid = ({1'b0, black_lv[it.slot]} + white_lv[it.slot]) >> 1;
        hit = (it.sample > mid) ^ cfg_m.line_white;
        if (hit && !scan_bits_m[it.slot]) begin
          scan_bits_m[it.slot] = 1'b1;
          wsum_m = wsum_m + WSUM_W'(1500 - 100 * int'(it.slot));
          hits_m = hits_m + 1'b1;
        end
        if (it.last) begin
          pos = (hits_m != 0) ? int'(wsum_m) / int'(hits_m) : 0;
          if (pos > 1500) pos = 1500;
          e = longint'(pos) - longint'(cfg_m.setpoint);
          d = e - longint'(prev_err_m);
          term = longint'(cfg_m.gain_p) * e + longint'(cfg_m.gain_d) * d
               + longint'(cfg_m.gain_i) * (e + d);
          r.duty_a    = clamp_duty(longint'(cfg_m.base_duty_a) + term, cfg_m.max_duty);
          r.duty_b    = clamp_duty(longint'(cfg_m.base_duty_b) - term, cfg_m.max_duty);
          r.position  = POS_W'(pos);
          r.pos_error = ERR_W'(e);
          r.line_bits = scan_bits_m;
          r.no_line   = (hits_m == 0);
          steer_q.push_back(r);
          prev_err_m  = r.pos_error;
          scan_bits_m = '0;
          wsum_m      = '0;
          hits_m      = '0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic bit field_ok(string fname, longint exp_v, longint got_v);
    if (exp_v == got_v) return 1'b1;
    $error("%s mismatch: expected %0d, got %0d", fname, exp_v, got_v);
    return 1'b0;
  endfunction

  // Sender: next item goes out once the current one has been taken.
  always @(negedge clk_i) begin
    sensor_item_t it;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_q.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.func        <= it.func;
        in_ch.sensor_slot <= it.slot;
        in_ch.sample      <= it.sample;
        in_ch.last        <= it.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predict on every input transaction, check every result transaction.
  always @(posedge clk_i) begin
    steer_result_t want;
    bit            ok;
    in_took <= in_ch.valid && in_ch.ready;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (steer_q.size() == 0) begin
        $error("result transaction with no expected result pending");
        fails++;
      end else begin
        want = steer_q.pop_front();
        ok = field_ok("duty_a", want.duty_a, out_ch.duty_a)
           & field_ok("duty_b", want.duty_b, out_ch.duty_b)
           & field_ok("position", want.position, out_ch.position)
           & field_ok("pos_error", want.pos_error, out_ch.pos_error)
           & field_ok("line_bits", want.line_bits, out_ch.line_bits)
           & field_ok("no_line", want.no_line, out_ch.no_line);
        if (!ok) fails++;
      end
    end
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      track_sample('{in_ch.func, in_ch.sensor_slot, in_ch.sample, in_ch.last});
      n_taken++;
    end
  end

  // Long output stall so the block backs up into its input.
  initial begin : long_hold
    wait (hold_go);
    recv_hold = 1'b1;
    repeat (400) @(posedge clk_i);
    recv_hold = 1'b0;
  end

  initial begin : watchdog
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic queue_item(logic [1:0] func, logic [SLOT_W-1:0] slot,
                            logic [SAMPLE_W-1:0] sample, logic last);
    pending_q.push_back('{func, slot, sample, last});
    n_queued++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int sel;
    sel = $urandom_range(99);
    if (sel < 12) return '0;
    if (sel < 24) return '1;
    return SAMPLE_W'($urandom_range(4095));
  endfunction

  // Calibration burst: either a whole bar with sane levels or a few random slots.
  task automatic queue_cal(ref int cnt);
    int n;
    if ($urandom_range(1) == 0) begin
      for (int s = 0; s < 16; s++) begin
        queue_item(FUNC_BLACK, SLOT_W'(s), SAMPLE_W'($urandom_range(2500, 4095)), 1'b0);
        queue_item(FUNC_WHITE, SLOT_W'(s), SAMPLE_W'($urandom_range(1500)), 1'b0);
      end
      cnt += 32;
    end else begin
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
        queue_item(FUNC_BLACK, SLOT_W'($urandom_range(15)), pick_sample(),
                   1'($urandom_range(1)));
        queue_item(FUNC_WHITE, SLOT_W'($urandom_range(15)), pick_sample(),
                   1'($urandom_range(1)));
      end
      cnt += 2 * n;
    end
  endtask

  task automatic queue_scan(ref int cnt);
    int len, start;
    bit shuffled;
    len = ($urandom_range(4) != 0) ? 16 : $urandom_range(1, 16);
    start = $urandom_range(15);
    shuffled = ($urandom_range(3) == 0);
    for (int k = 0; k < len; k++) begin
      queue_item(FUNC_RUN, SLOT_W'(shuffled ? $urandom_range(15) : (start + k) % 16),
                 pick_sample(), k == len - 1);
    end
    cnt += len;
  endtask

  task automatic queue_phase(int target);
    int cnt, sel;
    logic [1:0] f;
    cnt = 0;
    while (cnt < target) begin
      sel = $urandom_range(99);
      if (sel < 12) begin
        queue_cal(cnt);
      end else if (sel < 22) begin
        f = 2'($urandom_range(3));
        queue_item(f, SLOT_W'($urandom_range(15)), SAMPLE_W'($urandom_range(4095)),
                   1'($urandom_range(1)));
        if (f != FUNC_UNUSED) cnt++;
      end else begin
        queue_scan(cnt);
      end
    end
  endtask

  task automatic drain();
    while (n_taken != n_queued || steer_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    case (idx)
      CFG_GAIN_P:     cfg_m.gain_p = val[GAIN_W-1:0];
      CFG_GAIN_D:     cfg_m.gain_d = val[GAIN_W-1:0];
      CFG_GAIN_I:     cfg_m.gain_i = val[GAIN_W-1:0];
      CFG_BASE_A:     cfg_m.base_duty_a = val;
      CFG_BASE_B:     cfg_m.base_duty_b = val;
      CFG_MAX_DUTY:   cfg_m.max_duty = val;
      CFG_LINE_WHITE: cfg_m.line_white = val[0];
      CFG_SETPOINT:   cfg_m.setpoint = val[POS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(cfg_t c);
    write_reg(CFG_GAIN_P, CFG_DATA_W'(c.gain_p));
    write_reg(CFG_GAIN_D, CFG_DATA_W'(c.gain_d));
    write_reg(CFG_GAIN_I, CFG_DATA_W'(c.gain_i));
    write_reg(CFG_BASE_A, c.base_duty_a);
    write_reg(CFG_BASE_B, c.base_duty_b);
    write_reg(CFG_MAX_DUTY, c.max_duty);
    write_reg(CFG_LINE_WHITE, CFG_DATA_W'(c.line_white));
    write_reg(CFG_SETPOINT, CFG_DATA_W'(c.setpoint));
    cfg_we_i <= 1'b0;
  endtask

  // Small gains most of the time so the duties land inside the clamp window.
  function automatic cfg_t random_cfg();
    cfg_t c;
    c.gain_p = ($urandom_range(3) == 0) ? GAIN_W'($urandom_range(255))
                                        : GAIN_W'($urandom_range(6));
    c.gain_d = ($urandom_range(3) == 0) ? GAIN_W'($urandom_range(255))
                                        : GAIN_W'($urandom_range(6));
    c.gain_i = ($urandom_range(3) == 0) ? GAIN_W'($urandom_range(255))
                                        : GAIN_W'($urandom_range(6));
    c.base_duty_a = ($urandom_range(4) == 0) ? DUTY_W'($urandom) : DUTY_W'($urandom_range(3000));
    c.base_duty_b = ($urandom_range(4) == 0) ? DUTY_W'($urandom) : DUTY_W'($urandom_range(3000));
    c.max_duty = ($urandom_range(4) == 0) ? DUTY_W'($urandom) : DUTY_W'($urandom_range(1000, 5000));
    c.line_white = 1'($urandom_range(1));
    c.setpoint = POS_W'($urandom_range(1500));
    return c;
  endfunction

  initial begin : main
    cfg_t plan [6];
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_wdata_i       = '0;
    in_ch.valid       = 1'b0;
    in_ch.func        = '0;
    in_ch.sensor_slot = '0;
    in_ch.sample      = '0;
    in_ch.last        = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_m = '{gain_p: 8'd2, gain_d: 8'd0, gain_i: 8'd0, base_duty_a: 16'd500,
              base_duty_b: 16'd800, max_duty: 16'd2506, line_white: 1'b0,
              setpoint: 11'd750};
    for (int s = 0; s < 16; s++) begin
      black_lv[s] = '0;
      white_lv[s] = '0;
    end
    scan_bits_m = '0;
    wsum_m      = '0;
    hits_m      = '0;
    prev_err_m  = '0;

    plan[0] = '{8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 11'd1500};
    plan[1] = '{8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0, 11'd0};
    for (int k = 2; k < 6; k++) plan[k] = random_cfg();

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part under reset defaults; levels start at zero so mid is zero.
    queue_item(FUNC_RUN, 4'd0, 12'd4095, 1'b0);
    queue_item(FUNC_RUN, 4'd15, 12'd1, 1'b1);
    queue_item(FUNC_RUN, 4'd7, 12'd0, 1'b1);        // nothing seen: no line
    queue_item(FUNC_UNUSED, 4'd9, 12'd4095, 1'b1);  // ignored code
    queue_item(FUNC_BLACK, 4'd0, 12'd0, 1'b0);
    queue_item(FUNC_WHITE, 4'd0, 12'd4095, 1'b0);
    queue_item(FUNC_BLACK, 4'd15, 12'd4095, 1'b1);
    queue_item(FUNC_WHITE, 4'd15, 12'd4095, 1'b1);
    queue_item(FUNC_RUN, 4'd0, 12'd2048, 1'b0);
    queue_item(FUNC_RUN, 4'd0, 12'd0, 1'b0);        // repeated slot stays set
    queue_item(FUNC_RUN, 4'd15, 12'd4095, 1'b1);    // equal to mid: no hit
    queue_item(FUNC_RUN, 4'd14, 12'd1, 1'b0);
    queue_item(FUNC_RUN, 4'd1, 12'd4095, 1'b0);
    queue_item(FUNC_RUN, 4'd14, 12'd4095, 1'b1);
    queue_item(FUNC_RUN, 4'd0, 12'd2047, 1'b1);
    queue_item(FUNC_BLACK, 4'd0, 12'd4095, 1'b0);
    queue_item(FUNC_WHITE, 4'd0, 12'd0, 1'b0);
    queue_item(FUNC_RUN, 4'd0, 12'd4095, 1'b1);
    drain();

    for (int k = 0; k < 6; k++) begin
      load_cfg(plan[k]);
      if (k == 2) begin
        send_idle_pct = 63;
        recv_idle_pct = 38;
      end else if (k == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      queue_phase(PHASE_ITEMS);
      if (k == 4) hold_go = 1'b1;
      drain();
    end

    if (fails == 0 && steer_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
